/* rtl/hfsb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfsb_pkg
// Shared types and constants of the frequency-shift burst block.
// ----------------------------------------------------------------------------
package hfsb_pkg;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DIV,
		S_DIV_END,
		S_SINE,
		S_MOD_MUL,
		S_MOD_ACC,
		S_STEP_MUL,
		S_STEP_ACC,
		S_AP_MUL,
		S_AP_ACC,
		S_COS_DONE,
		S_OUT_MUL1,
		S_OUT_ACC1,
		S_OUT_MUL2,
		S_OUT_ACC2,
		S_FRAME_END,
		S_DONE
	} state_t;

	// configuration register indexes
	localparam logic [1:0] REG_SHIFT = 2'd0;
	localparam logic [1:0] REG_DEPTH = 2'd1;
	localparam logic [1:0] REG_SCALE = 2'd2;

	localparam int SHIFT_W = 14;
	localparam int DEPTH_W = 12;
	localparam int SCALE_W = 26;
	localparam logic [SHIFT_W-1:0] SHIFT_RST = 14'd480;
	localparam logic [DEPTH_W-1:0] DEPTH_RST = 12'd0;
	localparam logic [SCALE_W-1:0] SCALE_RST = 26'd22906492;

	// odd sine polynomial in Q30
	localparam logic signed [32:0] SIN_A1 = 33'sd1686629713;
	localparam logic signed [32:0] SIN_A3 = 33'sd693598668;
	localparam logic signed [32:0] SIN_A5 = 33'sd85569278;
	localparam logic signed [32:0] SIN_A7 = 33'sd5026942;
	localparam logic signed [32:0] SIN_A9 = 33'sd172272;

	localparam logic signed [23:0] SIN_MAX = 24'sd8388607;

	// dividend width of the modulation step division (2^33 + len/2)
	localparam int DIV_BITS = 34;

	// allpass coefficients, unsigned Q1.23
	function automatic logic [23:0] ap_coef(input logic [1:0] j);
		logic [23:0] c;
		case (j)
			2'd0: c = 24'd5808170;
			2'd1: c = 24'd7852286;
			2'd2: c = 24'd8289870;
			default: c = 24'd8378113;
		endcase
		return c;
	endfunction

endpackage

/* rtl/hilbert_frequency_shift_burst_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_frequency_shift_burst_top
// Timed allpass-Hilbert frequency-shift burst on a stereo sample stream.
// ----------------------------------------------------------------------------
// A sample frame inside a burst processes each channel in turn, plus input,
// modulation sine, step and output work, paced by the single shared multiplier:
// every product is registered between an issue and a consume state. A frame
// outside a burst goes straight to output, a start command to the serial divider.
// One item at a time; the output register lets the next item enter early.
// arst_n clears all state: registers at their reset values, no burst running.
module hilbert_frequency_shift_burst_top #(
	parameter int CHANNELS         = 2,
	parameter int SAMPLE_BITS      = 24,
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int BURST_LEN_BITS   = 18
) (
	input  logic clk,
	input  logic arst_n,
	// sample_left, sample_right, burst_length, zero pad
	input  logic [((2*SAMPLE_BITS+BURST_LEN_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  logic s_axis_tuser,   // cmd
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// shifted_left, shifted_right, zero pad
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic m_axis_tuser,   // burst_active
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [hfsb_pkg::SCALE_W-1:0] cfg_data
);
	import hfsb_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int BL    = BURST_LEN_BITS;
	localparam int YW    = SB + 2;
	localparam int MW    = (SB + 3 > 33) ? SB + 3 : 33;
	localparam int PW    = 2 * MW;
	localparam int TB    = $clog2(SINE_TABLE_DEPTH);
	localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int OUT_W = ((2*SB+7)/8)*8;
	localparam int AW    = SB + 5;
	localparam logic [31:0] U_MASK = ~((32'd1 << (32 - TB)) - 32'd1);
	localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);
	localparam logic signed [AW-1:0] Y_MAX = AW'((64'sd1 <<< (YW-1)) - 64'sd1);
	localparam logic signed [AW-1:0] Y_MIN = -Y_MAX - AW'(1);
	localparam logic signed [PW-1:0] O_MAX = PW'((64'sd1 <<< (SB-1)) - 64'sd1);
	localparam logic signed [PW-1:0] O_MIN = -O_MAX - PW'(1);
	localparam logic signed [PW-1:0] RND23 = PW'(64'sd1 <<< 22);

	state_t state_q, state_d;

	// configuration
	logic signed [SHIFT_W-1:0] shift_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [SCALE_W-1:0] scale_q;

	// burst state
	logic running_q;
	logic signed [SB-1:0] xh_q [CHANNELS][4];
	logic signed [YW-1:0] yh_q [CHANNELS][4];
	logic [31:0] ph_q [CHANNELS];
	logic [31:0] mph_q, mstep_q;
	logic [BL-1:0] pos_q, total_q;
	logic signed [SHIFT_W-1:0] cshift_q;

	// sequencer and datapath
	logic [5:0] div_cnt_q;
	logic [DIV_BITS-1:0] div_n_q;
	logic [BL-1:0] rem_q;
	logic [3:0] sin_k_q;
	state_t sin_ret_q;
	logic [31:0] sin_arg_q;
	logic [30:0] x_q, x2_q;
	logic [1:0] quad_q;
	logic signed [32:0] p_q;
	logic signed [23:0] sin_res_q, cs_q;
	logic signed [12:0] mod_q;
	logic [31:0] step_q;
	logic [CW-1:0] ch_q;
	logic [1:0] stg_q;
	logic signed [SB-1:0] xcur_q;
	logic signed [YW-1:0] y_q, q_q;
	logic signed [SB-1:0] smp_q [2];
	logic signed [SB-1:0] res_q [2];
	logic signed [PW-1:0] prod_q, acc_q;
	logic signed [MW-1:0] mul_a, mul_b;

	// output register
	logic out_valid_q, out_act_q;
	logic signed [SB-1:0] out_l_q, out_r_q;

	logic in_acc;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_act_q;
	assign m_axis_tdata = OUT_W'({out_r_q, out_l_q});

	// sine argument folding
	logic [31:0] u_w;
	logic [30:0] xs_w;
	assign u_w = sin_arg_q & U_MASK;
	assign xs_w = u_w[30] ? (31'h4000_0000 - {1'b0, u_w[29:0]}) : {1'b0, u_w[29:0]};

	// sine final rounding and clamp
	logic signed [PW-1:0] t_w, r_w;
	logic signed [23:0] sin_fin;
	always_comb begin
		t_w = prod_q >>> 30;
		r_w = (t_w + PW'(64)) >>> 7;
		if (r_w < 0)
			sin_fin = '0;
		else if (r_w > PW'(SIN_MAX))
			sin_fin = SIN_MAX;
		else
			sin_fin = r_w[23:0];
		if (quad_q[1])
			sin_fin = -sin_fin;
	end

	// allpass update
	logic signed [PW-1:0] ap_rnd;
	logic signed [AW-1:0] ap_sum;
	logic signed [YW-1:0] ap_y;
	logic signed [SB-1:0] ap_x;
	always_comb begin
		ap_rnd = (prod_q + RND23) >>> 23;
		ap_sum = AW'(ap_rnd) + AW'(xh_q[ch_q][stg_q]);
		if (ap_sum > Y_MAX)
			ap_y = Y_MAX[YW-1:0];
		else if (ap_sum < Y_MIN)
			ap_y = Y_MIN[YW-1:0];
		else
			ap_y = ap_sum[YW-1:0];
		if (AW'(ap_y) > AW'(O_MAX))
			ap_x = O_MAX[SB-1:0];
		else if (AW'(ap_y) < AW'(O_MIN))
			ap_x = O_MIN[SB-1:0];
		else
			ap_x = ap_y[SB-1:0];
	end

	// output sample rounding and saturation
	logic signed [PW-1:0] o_rnd;
	logic signed [SB-1:0] o_sat;
	always_comb begin
		o_rnd = (acc_q - prod_q + RND23) >>> 23;
		if (o_rnd > O_MAX)
			o_sat = O_MAX[SB-1:0];
		else if (o_rnd < O_MIN)
			o_sat = O_MIN[SB-1:0];
		else
			o_sat = o_rnd[SB-1:0];
	end

	// divider trial subtract
	logic [BL:0] trial_w;
	logic qbit_w;
	assign trial_w = {rem_q, div_n_q[DIV_BITS-1]};
	assign qbit_w = (trial_w >= {1'b0, total_q});

	logic [BL-1:0] len_w, pos_next;
	assign len_w = (s_axis_tdata[2*SB +: BL] == '0) ? BL'(1) : s_axis_tdata[2*SB +: BL];
	assign pos_next = pos_q + BL'(1);

	// shared multiplier operand selection and next state
	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (s_axis_tuser)
						state_d = running_q ? S_IDLE : S_DIV;
					else
						state_d = running_q ? S_SINE : S_DONE;
				end
			end
			S_DIV: begin
				if (div_cnt_q == '0)
					state_d = S_DIV_END;
			end
			S_DIV_END: state_d = S_IDLE;
			S_SINE: begin
				case (sin_k_q)
					4'd0: begin
						mul_a = MW'($signed({1'b0, xs_w}));
						mul_b = MW'($signed({1'b0, xs_w}));
					end
					4'd10: begin
						mul_a = MW'(p_q);
						mul_b = MW'($signed({1'b0, x_q}));
					end
					default: begin
						mul_a = MW'(p_q);
						mul_b = MW'($signed({1'b0, x2_q}));
					end
				endcase
				if (sin_k_q == 4'd11)
					state_d = sin_ret_q;
			end
			S_MOD_MUL: begin
				mul_a = MW'($signed({1'b0, depth_q}));
				mul_b = MW'(sin_res_q);
				state_d = S_MOD_ACC;
			end
			S_MOD_ACC: state_d = S_STEP_MUL;
			S_STEP_MUL: begin
				mul_a = MW'(cshift_q) + MW'(mod_q);
				mul_b = MW'($signed({1'b0, scale_q}));
				state_d = S_STEP_ACC;
			end
			S_STEP_ACC: state_d = S_AP_MUL;
			S_AP_MUL: begin
				mul_a = MW'($signed({1'b0, ap_coef(stg_q)}));
				mul_b = MW'(xcur_q) - MW'(yh_q[ch_q][stg_q]);
				state_d = S_AP_ACC;
			end
			S_AP_ACC: state_d = (stg_q == 2'd3) ? S_SINE : S_AP_MUL;
			S_COS_DONE: state_d = S_SINE;
			S_OUT_MUL1: begin
				mul_a = MW'(y_q);
				mul_b = MW'(cs_q);
				state_d = S_OUT_ACC1;
			end
			S_OUT_ACC1: state_d = S_OUT_MUL2;
			S_OUT_MUL2: begin
				mul_a = MW'(q_q);
				mul_b = MW'(sin_res_q);
				state_d = S_OUT_ACC2;
			end
			S_OUT_ACC2: state_d = (ch_q == LAST_CH) ? S_FRAME_END : S_AP_MUL;
			S_FRAME_END: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || m_axis_tready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SHIFT_RST;
			depth_q <= DEPTH_RST;
			scale_q <= SCALE_RST;
			running_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				ph_q[c] <= '0;
				for (int j = 0; j < 4; j++) begin
					xh_q[c][j] <= '0;
					yh_q[c][j] <= '0;
				end
			end
			mph_q <= '0;
			mstep_q <= '0;
			pos_q <= '0;
			total_q <= '0;
			cshift_q <= '0;
			div_cnt_q <= '0;
			div_n_q <= '0;
			rem_q <= '0;
			sin_k_q <= '0;
			sin_ret_q <= S_IDLE;
			sin_arg_q <= '0;
			x_q <= '0;
			x2_q <= '0;
			quad_q <= '0;
			p_q <= '0;
			sin_res_q <= '0;
			cs_q <= '0;
			mod_q <= '0;
			step_q <= '0;
			ch_q <= '0;
			stg_q <= '0;
			xcur_q <= '0;
			y_q <= '0;
			q_q <= '0;
			smp_q[0] <= '0;
			smp_q[1] <= '0;
			res_q[0] <= '0;
			res_q[1] <= '0;
			prod_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
			out_act_q <= 1'b0;
			out_l_q <= '0;
			out_r_q <= '0;
		end else begin
			prod_q <= PW'(mul_a) * PW'(mul_b);

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SHIFT: shift_q <= cfg_data[SHIFT_W-1:0];
					REG_DEPTH: depth_q <= cfg_data[DEPTH_W-1:0];
					REG_SCALE: scale_q <= cfg_data;
					default: ;
				endcase
			end

			// a new result loads in the same cycle the old one is taken
			if (state_q == S_DONE && (!out_valid_q || m_axis_tready))
				out_valid_q <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						smp_q[0] <= s_axis_tdata[SB-1:0];
						smp_q[1] <= s_axis_tdata[2*SB-1:SB];
						res_q[0] <= '0;
						res_q[1] <= '0;
						out_act_q <= out_valid_q ? out_act_q : 1'b0;
						sin_arg_q <= mph_q;
						sin_ret_q <= S_MOD_MUL;
						sin_k_q <= '0;
						if (s_axis_tuser && !running_q) begin
							for (int c = 0; c < CHANNELS; c++) begin
								ph_q[c] <= '0;
								for (int j = 0; j < 4; j++) begin
									xh_q[c][j] <= '0;
									yh_q[c][j] <= '0;
								end
							end
							mph_q <= '0;
							pos_q <= '0;
							total_q <= len_w;
							cshift_q <= shift_q;
							running_q <= 1'b1;
							div_n_q <= {2'b10, 32'(len_w >> 1)};
							rem_q <= '0;
							div_cnt_q <= 6'(DIV_BITS - 1);
						end
					end
				end
				S_DIV: begin
					rem_q <= qbit_w ? BL'(trial_w - {1'b0, total_q}) : trial_w[BL-1:0];
					div_n_q <= {div_n_q[DIV_BITS-2:0], qbit_w};
					div_cnt_q <= div_cnt_q - 6'd1;
				end
				S_DIV_END: mstep_q <= div_n_q[31:0];
				S_SINE: begin
					sin_k_q <= sin_k_q + 4'd1;
					case (sin_k_q)
						4'd0: begin
							x_q <= xs_w;
							quad_q <= u_w[31:30];
						end
						4'd1: begin
							x2_q <= prod_q[60:30];
							p_q <= SIN_A9;
						end
						4'd3: p_q <= 33'(prod_q >>> 30) - SIN_A7;
						4'd5: p_q <= 33'(prod_q >>> 30) + SIN_A5;
						4'd7: p_q <= 33'(prod_q >>> 30) - SIN_A3;
						4'd9: p_q <= 33'(prod_q >>> 30) + SIN_A1;
						4'd11: begin
							sin_res_q <= sin_fin;
							sin_k_q <= '0;
						end
						default: ;
					endcase
				end
				S_MOD_ACC: mod_q <= 13'((prod_q + RND23) >>> 23);
				S_STEP_ACC: begin
					step_q <= prod_q[43:12];
					ch_q <= '0;
					stg_q <= '0;
					xcur_q <= smp_q[0];
				end
				S_AP_ACC: begin
					xh_q[ch_q][stg_q] <= xcur_q;
					yh_q[ch_q][stg_q] <= ap_y;
					xcur_q <= ap_x;
					y_q <= ap_y;
					if (stg_q == 2'd1)
						q_q <= ap_y;
					stg_q <= stg_q + 2'd1;
					if (stg_q == 2'd3) begin
						sin_arg_q <= ph_q[ch_q] + 32'h4000_0000;
						sin_ret_q <= S_COS_DONE;
					end
				end
				S_COS_DONE: begin
					cs_q <= sin_res_q;
					sin_arg_q <= ph_q[ch_q];
					sin_ret_q <= S_OUT_MUL1;
				end
				S_OUT_ACC1: acc_q <= prod_q;
				S_OUT_ACC2: begin
					res_q[ch_q] <= o_sat;
					ph_q[ch_q] <= ph_q[ch_q] + step_q;
					if (ch_q != LAST_CH) begin
						ch_q <= ch_q + CW'(1);
						stg_q <= '0;
						xcur_q <= smp_q[1];
					end
				end
				S_FRAME_END: begin
					mph_q <= mph_q + mstep_q;
					pos_q <= pos_next;
					if (pos_next >= total_q)
						running_q <= 1'b0;
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_act_q <= (sin_ret_q == S_OUT_MUL1);
						out_l_q <= res_q[0];
						out_r_q <= res_q[1];
					end
				end
				default: ;
			endcase
		end
	end

	// a result outside a burst carries zero samples
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("inactive result with nonzero samples");

	// a frame outside a burst goes straight to the output stage
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !s_axis_tuser && !running_q |=> state_q == S_DONE)
		else $error("idle frame did not go to output");

	// the serial divider ends after its last bit
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && div_cnt_q == '0 |=> state_q == S_DIV_END)
		else $error("divider overran");

endmodule

/* bench/hilbert_frequency_shift_burst_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_frequency_shift_burst_top_tb
// Self-checking bench for the allpass-Hilbert frequency-shift burst block.
// ----------------------------------------------------------------------------
// Sample frames and start commands are sent over the input stream. A bit-true
// shifter model in the bench works out each expected output frame when its
// input transfer is accepted. A checker compares every output transfer with
// the oldest expected frame. Register settings change only while the block
// is idle. Both stream sides idle at random, and a long output hold fills the
// block up and stalls its input.
// ----------------------------------------------------------------------------
module hilbert_frequency_shift_burst_top_tb;
	import hfsb_pkg::*;

	localparam int SB = 24;
	localparam int LB = 18;
	localparam int SINE_DEPTH = 1024;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int TAIL_CYCLES = 300;
	localparam bit CMD_FRAME = 1'b0;
	localparam bit CMD_START = 1'b1;
	localparam longint AP_K [4] = '{5808170, 7852286, 8289870, 8378113};

	typedef struct {
		logic [SB-1:0] left;
		logic [SB-1:0] right;
		logic          active;
	} shifted_frame_t;

	logic clk;
	logic arst_n;
	logic [71:0] s_axis_tdata;
	logic s_axis_tuser;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [SCALE_W-1:0] cfg_data;

	hilbert_frequency_shift_burst_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// model state
	longint shift_reg, depth_reg, scale_reg;
	longint ap_in_hist [2][4];
	longint ap_out_hist [2][4];
	logic [31:0] carrier_ph [2];
	logic [31:0] lfo_ph, lfo_step;
	logic [LB-1:0] burst_pos, burst_len_q;
	longint burst_shift;
	bit in_burst;

	shifted_frame_t expected_frames[$];
	int src_idle, snk_idle;
	// a hold is requested by flipping hold_toggle; the sink owns the count
	int hold_len;
	bit hold_toggle;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int mismatches = 0;
	int frames_seen = 0;
	int items_sent, bursts_started;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint sat_to(longint v, int bits);
		longint hi, lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic longint sine_q23(logic [31:0] ph);
		longint unsigned idx, u;
		longint x, x2, p, r;
		logic [1:0] quad;
		idx = ({32'b0, ph} * SINE_DEPTH) >> 32;
		u = (idx << 32) / SINE_DEPTH;
		quad = u[31:30];
		x = longint'(u & 64'h3FFF_FFFF);
		if (quad[0])
			x = (longint'(1) <<< 30) - x;
		x2 = (x * x) >>> 30;
		p = longint'(SIN_A9);
		p = ((p * x2) >>> 30) - longint'(SIN_A7);
		p = ((p * x2) >>> 30) + longint'(SIN_A5);
		p = ((p * x2) >>> 30) - longint'(SIN_A3);
		p = ((p * x2) >>> 30) + longint'(SIN_A1);
		r = (((p * x) >>> 30) + 64) >>> 7;
		if (r < 0) r = 0;
		if (r > 8388607) r = 8388607;
		return quad[1] ? -r : r;
	endfunction

	function automatic void model_reset();
		shift_reg = 480;
		depth_reg = 0;
		scale_reg = 22906492;
		foreach (ap_in_hist[c, j]) begin
			ap_in_hist[c][j] = 0;
			ap_out_hist[c][j] = 0;
		end
		carrier_ph = '{32'd0, 32'd0};
		lfo_ph = 0;
		lfo_step = 0;
		burst_pos = 0;
		burst_len_q = 0;
		burst_shift = 0;
		in_burst = 0;
	endfunction

	// advance the shifter model by one accepted item
	function automatic void predict_shift(bit cmd, logic [SB-1:0] l, logic [SB-1:0] r,
			logic [LB-1:0] len);
		shifted_frame_t f;
		longint lfo_mod, step, x, y, q, cs, sn, d;
		longint res [2];
		longint unsigned n;
		if (cmd == CMD_START) begin
			if (in_burst)
				return;
			n = (len == 0) ? 1 : len;
			foreach (ap_in_hist[c, j]) begin
				ap_in_hist[c][j] = 0;
				ap_out_hist[c][j] = 0;
			end
			carrier_ph = '{32'd0, 32'd0};
			lfo_ph = 0;
			lfo_step = 32'(((64'd1 << 33) + (n >> 1)) / n);
			burst_pos = 0;
			burst_len_q = LB'(n);
			burst_shift = shift_reg;
			in_burst = 1;
			bursts_started++;
			return;
		end
		if (!in_burst) begin
			f.left = 0;
			f.right = 0;
			f.active = 0;
			expected_frames = {expected_frames, f};
			return;
		end
		lfo_mod = (depth_reg * sine_q23(lfo_ph) + (longint'(1) <<< 22)) >>> 23;
		step = ((burst_shift + lfo_mod) * scale_reg) >>> 12;
		for (int c = 0; c < 2; c++) begin
			x = (c == 0) ? longint'($signed(l)) : longint'($signed(r));
			q = 0;
			y = 0;
			for (int j = 0; j < 4; j++) begin
				d = x - ap_out_hist[c][j];
				y = ((AP_K[j] * d + (longint'(1) <<< 22)) >>> 23) + ap_in_hist[c][j];
				y = sat_to(y, SB + 2);
				ap_in_hist[c][j] = x;
				ap_out_hist[c][j] = y;
				if (j == 1) q = y;
				x = sat_to(y, SB);
			end
			cs = sine_q23(carrier_ph[c] + 32'h4000_0000);
			sn = sine_q23(carrier_ph[c]);
			res[c] = sat_to((y * cs - q * sn + (longint'(1) <<< 22)) >>> 23, SB);
			carrier_ph[c] = carrier_ph[c] + step[31:0];
		end
		lfo_ph = lfo_ph + lfo_step;
		burst_pos = burst_pos + 1'b1;
		if (burst_pos >= burst_len_q)
			in_burst = 0;
		f.left = res[0][SB-1:0];
		f.right = res[1][SB-1:0];
		f.active = 1;
		expected_frames = {expected_frames, f};
	endfunction

	// one input transfer, predicted on acceptance
	task automatic send_item(bit cmd, logic [SB-1:0] l, logic [SB-1:0] r, logic [LB-1:0] len);
		if ($urandom_range(99) < src_idle) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tdata = {6'b0, len, r, l};
		s_axis_tuser = cmd;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predict_shift(cmd, l, r, len);
		items_sent++;
	endtask

	task automatic send_frame();
		send_item(CMD_FRAME, SB'($urandom), SB'($urandom), LB'($urandom));
	endtask

	task automatic send_start(logic [LB-1:0] len);
		send_item(CMD_START, SB'($urandom), SB'($urandom), len);
	endtask

	// block is idle: all frames back, plus slack for a start that gives no frame
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [SCALE_W-1:0] value);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SHIFT: shift_reg = longint'($signed(value[SHIFT_W-1:0]));
			REG_DEPTH: depth_reg = longint'(value[DEPTH_W-1:0]);
			REG_SCALE: scale_reg = longint'(value);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_shift(int hz16);
		write_reg(REG_SHIFT, SCALE_W'(unsigned'(hz16) & 32'h3FFF));
	endtask

	task automatic test_directed();
		send_frame();
		send_item(CMD_FRAME, 24'h7FFFFF, 24'h800000, 18'h3FFFF);
		send_start(18'd0);
		send_item(CMD_FRAME, 24'h7FFFFF, 24'h800000, 18'd0);
		send_frame();
		send_start(18'd6);
		send_start(18'd3);
		send_item(CMD_FRAME, 24'h7FFFFF, 24'h7FFFFF, 18'd0);
		send_item(CMD_FRAME, 24'h800000, 24'h800000, 18'd0);
		send_item(CMD_FRAME, 24'h7FFFFF, 24'h800000, 18'd0);
		send_item(CMD_FRAME, 24'h800000, 24'h7FFFFF, 18'd0);
		send_item(CMD_FRAME, 24'h000000, 24'hFFFFFF, 18'd0);
		send_item(CMD_FRAME, 24'h000001, 24'h000000, 18'd0);
		send_frame();
		wait_drained();
		set_shift(8000);
		write_reg(REG_DEPTH, 26'd4095);
		write_reg(REG_SCALE, 26'h3FFFFFF);
		send_start(18'd8);
		repeat (9) send_item(CMD_FRAME, 24'h7FFFFF, 24'h800000, 18'd0);
		wait_drained();
	endtask

	// mostly well-formed bursts with random content, some stray items
	task automatic run_bursts(int n_items);
		int target, len;
		target = items_sent + n_items;
		while (items_sent < target) begin
			if ($urandom_range(9) < 8) begin
				len = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 40);
				send_start(LB'(len));
				for (int k = 0; k < len + $urandom_range(0, 2); k++) begin
					if ($urandom_range(29) == 0)
						send_start(LB'($urandom_range(1, 40)));
					send_frame();
				end
			end else begin
				send_item(bit'($urandom_range(1)), SB'($urandom), SB'($urandom),
					LB'($urandom_range(0, 8)));
			end
		end
		wait_drained();
	endtask

	task automatic test_random_traffic();
		src_idle = 22;
		snk_idle = 51;
		set_shift(-8000);
		write_reg(REG_DEPTH, 26'd3200);
		write_reg(REG_SCALE, 26'd22906492);
		run_bursts(600);
		src_idle = 51;
		snk_idle = 22;
		set_shift($urandom_range(0, 16000) - 8000);
		write_reg(REG_DEPTH, 26'd0);
		write_reg(REG_SCALE, 26'd0);
		run_bursts(500);
		src_idle = 0;
		snk_idle = 0;
		set_shift($urandom_range(0, 16000) - 8000);
		write_reg(REG_DEPTH, SCALE_W'($urandom_range(0, 3200)));
		write_reg(REG_SCALE, SCALE_W'($urandom));
		run_bursts(600);
	endtask

	// output side holds off while input keeps coming
	task automatic test_output_hold();
		src_idle = 0;
		snk_idle = 0;
		write_reg(REG_SCALE, 26'd22906492);
		hold_len = 3000;
		hold_toggle = ~hold_toggle;
		send_start(18'd30);
		repeat (30) send_frame();
		wait_drained();
	endtask

	// longest burst goes last, it never finishes within the run
	task automatic test_long_burst();
		src_idle = 22;
		snk_idle = 22;
		set_shift(480);
		send_start(18'h3FFFF);
		repeat (150) send_frame();
		send_start(18'd5);
		repeat (20) send_frame();
		wait_drained();
	endtask

	// output ready, with an occasional long hold
	always @(negedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= hold_len - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	always @(posedge clk) begin
		shifted_frame_t f;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			frames_seen++;
			if (expected_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output transfer: %h active %b",
						m_axis_tdata, m_axis_tuser);
			end else begin
				f = expected_frames.pop_front();
				if (m_axis_tdata[23:0] !== f.left || m_axis_tdata[47:24] !== f.right ||
						m_axis_tuser !== f.active) begin
					mismatches++;
					if (mismatches <= 10)
						$display("frame %0d mismatch: exp L %h R %h act %b, got L %h R %h act %b",
							frames_seen, f.left, f.right, f.active,
							m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tuser);
				end
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int leftover;
		arst_n = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tvalid = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SHIFT;
		cfg_data = '0;
		src_idle = 0;
		snk_idle = 0;
		hold_len = 0;
		hold_toggle = 1'b0;
		items_sent = 0;
		bursts_started = 0;
		model_reset();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_traffic();
		test_output_hold();
		test_long_burst();

		leftover = expected_frames.size();
		$display("sent %0d items, %0d bursts started, %0d output frames checked",
			items_sent, bursts_started, frames_seen);
		$display("covered register extremes, idle bursts, stalls and an output hold");
		if (mismatches == 0 && leftover == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d frames never seen", mismatches, leftover);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* hilbert_frequency_shift_burst_top.f */
rtl/hfsb_pkg.sv
rtl/hilbert_frequency_shift_burst_top.sv
bench/hilbert_frequency_shift_burst_top_tb.sv
